>>> rtl/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

   localparam int FUNC_W    = 3;
   localparam int INDEX_W   = 6;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;
   localparam int CALC_W    = 16;   // scratch width for index / count compares
   localparam int WIDE_W    = 64;   // widest supported word

   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND = 3'd0,
      FN_INSERT = 3'd1,
      FN_GET    = 3'd2,
      FN_SET    = 3'd3,
      FN_REMOVE = 3'd4,
      FN_CLEAR  = 3'd5
   } func_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic ins;   // target cell loads, cells above take their lower neighbour
      logic rmv;   // target and cells above take their upper neighbour
      logic wr;    // target cell loads in place
   } cell_ctl_type;

endpackage

>>> rtl/ils_cell.sv
`timescale 1ns / 1ps

module ils_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7,
   parameter int POS        = 0
) (
   input  logic                    clock,
   input  ils_pkg::cell_ctl_type   ctl,
   input  logic [CNT_W-1:0]        sel_pos,
   input  logic [DATA_WIDTH-1:0]   wr_word,
   input  logic [DATA_WIDTH-1:0]   left_word,
   input  logic [DATA_WIDTH-1:0]   right_word,
   output logic [DATA_WIDTH-1:0]   word,
   output logic [DATA_WIDTH-1:0]   rd_word
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

   logic                  hit;
   logic                  above;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   assign hit   = (sel_pos == MY_POS);
   assign above = (MY_POS > sel_pos);

   always_comb begin
      word_in = word_ff;
      if (ctl.ins) begin
         if (hit) begin
            word_in = wr_word;
         end else if (above) begin
            word_in = left_word;
         end
      end else if (ctl.rmv) begin
         if (hit || above) begin
            word_in = right_word;
         end
      end else if (ctl.wr) begin
         if (hit) begin
            word_in = wr_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = hit ? word_ff : '0;

endmodule

>>> rtl/indexed_list_store_unit.sv
`timescale 1ns / 1ps
// Result: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp_ready holds; the addressed cells
// shift or load that same cycle; the read word is an AND-OR pick across cells.
// Reset: synchronous, active high; clears the count and the result valid.
// Entry contents are not reset; only entries below the count are ever read.
// No clearing pass: the block takes requests straight after reset.

module indexed_list_store_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ils_pkg::FUNC_W-1:0]    req_func,
   input  logic [ils_pkg::INDEX_W-1:0]   req_index,
   input  logic [ils_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [ils_pkg::VALUE_W-1:0]   rsp_data,
   output logic [ils_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // handshake
   logic req_take;

   // list count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_ok_ff;
   logic                        rsp_ok_in;
   logic [ils_pkg::VALUE_W-1:0] rsp_data_ff;
   logic [ils_pkg::VALUE_W-1:0] rsp_data_in;
   logic [ils_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [ils_pkg::COUNT_W-1:0] rsp_count_in;

   // decode
   ils_pkg::func_type       func_e;
   ils_pkg::cell_ctl_type   ctl;
   ils_pkg::cell_ctl_type   ctl_gated;
   logic                    op_ok;
   logic                    use_rd;
   logic [CNT_W-1:0]        sel_pos;
   logic [ils_pkg::CALC_W-1:0] idx_wide;
   logic [ils_pkg::CALC_W-1:0] cnt_wide;
   logic [ils_pkg::CALC_W-1:0] cnt_next_wide;
   logic [ils_pkg::WIDE_W-1:0] val_wide;
   logic [ils_pkg::WIDE_W-1:0] rd_wide;

   // cell chain
   logic [DATA_WIDTH-1:0] wr_word;
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
   logic [DATA_WIDTH-1:0] rd_word;

   // a new word is taken whenever the result register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   assign func_e   = ils_pkg::func_type'(req_func);
   assign idx_wide = ils_pkg::CALC_W'(req_index);
   assign cnt_wide = ils_pkg::CALC_W'(count_ff);
   assign val_wide = ils_pkg::WIDE_W'(req_value);
   assign wr_word  = val_wide[DATA_WIDTH-1:0];

   // operation decode and bounds checks
   always_comb begin
      op_ok    = 1'b0;
      use_rd   = 1'b0;
      ctl      = '0;
      sel_pos  = CNT_W'(req_index);
      count_in = count_ff;
      case (func_e)
         ils_pkg::FN_APPEND: begin
            sel_pos = count_ff;
            if (cnt_wide < ils_pkg::CALC_W'(DEPTH)) begin
               op_ok    = 1'b1;
               ctl.ins  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ils_pkg::FN_INSERT: begin
            if ((idx_wide <= cnt_wide) && (cnt_wide < ils_pkg::CALC_W'(DEPTH))) begin
               op_ok    = 1'b1;
               ctl.ins  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ils_pkg::FN_GET: begin
            if (idx_wide < cnt_wide) begin
               op_ok  = 1'b1;
               use_rd = 1'b1;
            end
         end
         ils_pkg::FN_SET: begin
            if (idx_wide < cnt_wide) begin
               op_ok  = 1'b1;
               use_rd = 1'b1;
               ctl.wr = 1'b1;
            end
         end
         ils_pkg::FN_REMOVE: begin
            if (idx_wide < cnt_wide) begin
               op_ok    = 1'b1;
               use_rd   = 1'b1;
               ctl.rmv  = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ils_pkg::FN_CLEAR: begin
            op_ok    = 1'b1;
            count_in = '0;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // cells only move on an accepted word
   assign ctl_gated = req_take ? ctl : '0;

   // chain of cells: each holds one entry and sees both neighbours
   for (genvar p = 0; p < DEPTH; p++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      if (p == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[p-1];
      end

      if (p == DEPTH - 1) begin : g_last
         assign right_w = cell_word[p];
      end else begin : g_mid_r
         assign right_w = cell_word[p+1];
      end

      ils_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .POS        (p)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl_gated),
         .sel_pos    (sel_pos),
         .wr_word    (wr_word),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[p]),
         .rd_word    (cell_rd[p])
      );
   end

   // only the addressed cell drives a non-zero read word
   always_comb begin
      rd_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_word = rd_word | cell_rd[k];
      end
   end

   assign rd_wide       = ils_pkg::WIDE_W'(rd_word);
   assign cnt_next_wide = ils_pkg::CALC_W'(count_in);

   // result word, captured on acceptance
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = op_ok;
         rsp_data_in  = (op_ok && use_rd) ? rd_wide[ils_pkg::VALUE_W-1:0] : '0;
         rsp_count_in = cnt_next_wide[ils_pkg::COUNT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      ils_pkg::CALC_W'(count_ff) <= ils_pkg::CALC_W'(DEPTH))
      else $error("list count beyond depth");

   a_take_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_reject_no_data : assert property (@(posedge clock) disable iff (reset)
      (req_take && !op_ok) |=> (rsp_data_ff == '0) && ($stable(count_ff)))
      else $error("rejected word changed state or returned data");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (req_take && (func_e != ils_pkg::FN_CLEAR)) |=>
         ((count_ff == $past(count_ff)) ||
          (count_ff == $past(count_ff) + CNT_W'(1)) ||
          (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("count moved by more than one");
`endif

endmodule

>>> bench/tb_indexed_list_store_unit.sv
`timescale 1ns / 1ps

module tb_indexed_list_store_unit;

   localparam int STORE_DEPTH = 64;
   localparam int HALF_PERIOD = 6;      // 12 ns clock
   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;    // long result-side hold-off
   localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on either side
   localparam int END_SLACK = 8;        // registered result, plenty of margin

   // func codes the block must reject
   localparam logic [ils_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
   localparam logic [ils_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

   // result-side ready behaviour, changed every so often
   typedef enum int {RX_STREAM, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic                          ok;
      logic [ils_pkg::VALUE_W-1:0]   data;
      logic [ils_pkg::COUNT_W-1:0]   count;
   } list_outcome_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [ils_pkg::FUNC_W-1:0]    req_func;
   logic [ils_pkg::INDEX_W-1:0]   req_index;
   logic [ils_pkg::VALUE_W-1:0]   req_value;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_ok;
   logic [ils_pkg::VALUE_W-1:0]   rsp_data;
   logic [ils_pkg::COUNT_W-1:0]   rsp_count;

   // shadow copy of the list, advanced on every accepted request word
   logic [ils_pkg::VALUE_W-1:0]   list_words [STORE_DEPTH];
   int                            list_len = 0;
   list_outcome_type              pending_results [$];
   list_outcome_type              front_result;
   int                            mismatch_count = 0;

   // sender burst control
   int                            burst_left = 0;
   bit                            gaps_on = 1'b1;

   // receiver state
   int                            hold_asks = 0;
   int                            hold_seen = 0;
   int                            hold_left = 0;
   int                            mode_left = 0;
   rx_mode_type                   stall_mode = RX_STREAM;
   logic [15:0]                   stall_pattern = 16'h0;

   int                            quiet_cycles = 0;

   indexed_list_store_unit #(
      .DEPTH      (STORE_DEPTH),
      .DATA_WIDTH (ils_pkg::VALUE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_index (req_index),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_ok    (rsp_ok),
      .rsp_data  (rsp_data),
      .rsp_count (rsp_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // Works out the result of one request and moves the shadow list on.
   // Only positions below list_len are ever read, so unwritten entries never matter.
   function automatic list_outcome_type apply_request(logic [ils_pkg::FUNC_W-1:0] fn,
                                                      logic [ils_pkg::INDEX_W-1:0] idx,
                                                      logic [ils_pkg::VALUE_W-1:0] val);
      list_outcome_type res;
      int j;
      int pos;
      pos = int'(idx);
      res.ok = 1'b0;
      res.data = '0;
      case (fn)
         ils_pkg::FN_APPEND: begin
            if (list_len < STORE_DEPTH) begin
               list_words[list_len] = val;
               list_len++;
               res.ok = 1'b1;
            end
         end
         ils_pkg::FN_INSERT: begin
            // slide the tail up one place, then drop the word in
            if (pos <= list_len && list_len < STORE_DEPTH) begin
               for (j = list_len; j > pos; j--)
                  list_words[j] = list_words[j-1];
               list_words[pos] = val;
               list_len++;
               res.ok = 1'b1;
            end
         end
         ils_pkg::FN_GET: begin
            if (pos < list_len) begin
               res.ok = 1'b1;
               res.data = list_words[pos];
            end
         end
         ils_pkg::FN_SET: begin
            if (pos < list_len) begin
               res.ok = 1'b1;
               res.data = list_words[pos];
               list_words[pos] = val;
            end
         end
         ils_pkg::FN_REMOVE: begin
            if (pos < list_len) begin
               res.ok = 1'b1;
               res.data = list_words[pos];
               for (j = pos + 1; j < list_len; j++)
                  list_words[j-1] = list_words[j];
               list_len--;
            end
         end
         ils_pkg::FN_CLEAR: begin
            list_len = 0;
            res.ok = 1'b1;
         end
         default: ;  // spare codes: rejected, nothing moves
      endcase
      res.count = list_len[ils_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [ils_pkg::VALUE_W-1:0] want,
                                  logic [ils_pkg::VALUE_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
   endtask

   // Offers one request word and returns at the edge where it is taken.
   // Valid is left high; the next call or a pause decides what happens to it.
   task automatic send_word(logic [ils_pkg::FUNC_W-1:0] fn,
                            logic [ils_pkg::INDEX_W-1:0] idx,
                            logic [ils_pkg::VALUE_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = (gaps_on && $urandom_range(0, 9) > 2) ? int'($urandom_range(1, 10)) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func  <= fn;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_request(fn, idx, val));
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   // The check follows an edge, so valid is never lowered and raised in one step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // One random request; grow_pct steers the list towards full or empty.
   // Indices mostly land in range, the rest anywhere in the field.
   task automatic random_request(int grow_pct);
      logic [ils_pkg::FUNC_W-1:0] fn;
      logic [ils_pkg::INDEX_W-1:0] idx;
      int roll;
      int hi;
      roll = int'($urandom_range(0, 99));
      if (roll < 1)
         fn = ils_pkg::FN_CLEAR;
      else if (roll < 4)
         fn = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
      else if (roll < 4 + grow_pct)
         fn = $urandom_range(0, 1) ? ils_pkg::FN_APPEND : ils_pkg::FN_INSERT;
      else begin
         case ($urandom_range(0, 2))
            0:       fn = ils_pkg::FN_GET;
            1:       fn = ils_pkg::FN_SET;
            default: fn = ils_pkg::FN_REMOVE;
         endcase
      end
      hi = (fn == ils_pkg::FN_INSERT) ? list_len : list_len - 1;
      if (hi > STORE_DEPTH - 1)
         hi = STORE_DEPTH - 1;
      if (hi >= 0 && $urandom_range(0, 3) != 0)
         idx = ils_pkg::INDEX_W'($urandom_range(0, hi));
      else
         idx = ils_pkg::INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
      send_word(fn, idx, $urandom);
   endtask

   // Edge cases on a short list: empty rejects, spare codes, front / middle /
   // end inserts, reads and removes at both ends, index equal to the count, clear.
   task automatic test_directed_edges();
      send_word(ils_pkg::FN_GET,    6'd0,  32'h0000_0001);
      send_word(ils_pkg::FN_REMOVE, 6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_SET,    6'd0,  32'hDEAD_BEEF);
      send_word(ils_pkg::FN_INSERT, 6'd1,  32'h1111_1111);
      send_word(FN_SPARE_6,         6'd0,  32'h0000_0000);
      send_word(FN_SPARE_7,         6'd63, 32'hFFFF_FFFF);
      send_word(ils_pkg::FN_APPEND, 6'd63, 32'hFFFF_FFFF);
      send_word(ils_pkg::FN_APPEND, 6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_INSERT, 6'd0,  32'hA5A5_A5A5);
      send_word(ils_pkg::FN_INSERT, 6'd3,  32'h5A5A_5A5A);
      send_word(ils_pkg::FN_INSERT, 6'd2,  32'hC3C3_C3C3);
      send_word(ils_pkg::FN_GET,    6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_GET,    6'd4,  32'h0000_0000);
      send_word(ils_pkg::FN_GET,    6'd5,  32'h0000_0000);
      send_word(ils_pkg::FN_SET,    6'd4,  32'h0000_0000);
      send_word(ils_pkg::FN_SET,    6'd63, 32'h7777_7777);
      send_word(ils_pkg::FN_REMOVE, 6'd2,  32'h0000_0000);
      send_word(ils_pkg::FN_REMOVE, 6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_REMOVE, 6'd2,  32'h0000_0000);
      send_word(ils_pkg::FN_CLEAR,  6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_GET,    6'd0,  32'h0000_0000);
      send_word(ils_pkg::FN_CLEAR,  6'd21, 32'hFFFF_FFFF);
      send_word(ils_pkg::FN_APPEND, 6'd0,  32'h1234_5678);
   endtask

   // Fill to the brim, poke the full store, then empty it by random removes and reads.
   task automatic test_fill_and_drain();
      int r;
      while (list_len < STORE_DEPTH) begin
         if ($urandom_range(0, 1))
            send_word(ils_pkg::FN_APPEND,
                      ils_pkg::INDEX_W'($urandom_range(0, STORE_DEPTH - 1)), $urandom);
         else
            send_word(ils_pkg::FN_INSERT,
                      ils_pkg::INDEX_W'($urandom_range(0, list_len)), $urandom);
      end
      // full: appends and inserts bounce, top index is live
      send_word(ils_pkg::FN_APPEND, 6'd0,  $urandom);
      send_word(ils_pkg::FN_INSERT, 6'd0,  $urandom);
      send_word(ils_pkg::FN_INSERT, 6'd63, $urandom);
      send_word(ils_pkg::FN_GET,    6'd63, $urandom);
      send_word(ils_pkg::FN_SET,    6'd63, 32'hFFFF_FFFF);
      send_word(ils_pkg::FN_REMOVE, 6'd63, $urandom);
      send_word(ils_pkg::FN_INSERT, 6'd63, $urandom);
      send_word(ils_pkg::FN_GET,    6'd0,  $urandom);
      while (list_len > 0) begin
         r = int'($urandom_range(0, 3));
         if (r == 0)
            send_word(ils_pkg::FN_GET,
                      ils_pkg::INDEX_W'($urandom_range(0, list_len - 1)), $urandom);
         else if (r == 1 && list_len < STORE_DEPTH)
            send_word(ils_pkg::FN_REMOVE, ils_pkg::INDEX_W'(list_len),
                      $urandom);   // one past the end
         else
            send_word(ils_pkg::FN_REMOVE,
                      ils_pkg::INDEX_W'($urandom_range(0, list_len - 1)), $urandom);
      end
   endtask

   // Receiver holds off for a long stretch while words keep coming back to back,
   // so the block backs up and drops req_ready.
   task automatic test_output_stall();
      gaps_on = 1'b0;
      burst_left = 0;
      hold_asks++;
      repeat (40) random_request(50);
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // Long random run in phases, each leaning towards growth, shrinkage or balance.
   task automatic test_random_mix();
      int grow_pct;
      repeat (7) begin
         case ($urandom_range(0, 2))
            0:       grow_pct = 15;
            1:       grow_pct = 30;
            default: grow_pct = 55;
         endcase
         repeat (85) random_request(grow_pct);
      end
   endtask

   // Result checker: every word taken on the result side is matched against
   // the oldest prediction still waiting.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result word with nothing expected: ok %0b data %h count %0d",
                        $realtime, rsp_ok, rsp_data, rsp_count);
         end else begin
            front_result = pending_results.pop_front();
            if (rsp_ok !== front_result.ok)
               report_mismatch("ok", ils_pkg::VALUE_W'(front_result.ok),
                               ils_pkg::VALUE_W'(rsp_ok));
            if (rsp_data !== front_result.data)
               report_mismatch("data", front_result.data, rsp_data);
            if (rsp_count !== front_result.count)
               report_mismatch("count", ils_pkg::VALUE_W'(front_result.count),
                               ils_pkg::VALUE_W'(rsp_count));
         end
      end
   end

   // Receiver: a random mode every so often (always ready, coin toss, rotating
   // pattern, mostly stalled), overridden by a long hold-off when a test asks.
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         mode_left = int'($urandom_range(20, 120));
         stall_mode = rx_mode_type'($urandom_range(0, 3));
         stall_pattern = 16'($urandom);
      end
      mode_left--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_STREAM:  rsp_ready <= 1'b1;
            RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rsp_ready <= stall_pattern[0];
            default:    rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: too long with no word moving on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= ils_pkg::FN_APPEND;
      req_index <= '0;
      req_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      wait_drained();
      test_fill_and_drain();
      wait_drained();            // sender pauses until all results are back
      test_output_stall();
      test_random_mix();

      wait_drained();
      repeat (END_SLACK) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store_unit.sv
bench/tb_indexed_list_store_unit.sv
